[hdl/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, types and the sRGB curve functions that build the
// linearize and re-encode tables at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slt_pkg;

  // pixel and weight formats
  localparam int unsigned PixW            = 8;
  localparam int unsigned WeightBits      = 16;
  localparam int unsigned WeightW         = WeightBits + 1;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned NumLevels       = 256;
  localparam int unsigned NumEdges        = NumLevels - 1;

  // configuration register file
  localparam int unsigned RegDataW = 32;
  localparam int unsigned RegAddrW = 4;

  localparam logic [PixW-1:0]    ThresholdReset   = 8'd128;
  localparam logic [WeightW-1:0] RedWeightReset   = 17'd13933;
  localparam logic [WeightW-1:0] GreenWeightReset = 17'd46871;
  localparam logic [WeightW-1:0] BlueWeightReset  = 17'd4732;

  localparam logic [PixW-1:0] PixBlack = 8'd0;
  localparam logic [PixW-1:0] PixWhite = 8'd255;

  // curve evaluated at n/510; linear below the knee, power law above
  localparam int unsigned CurveLinKnee   = 20;
  localparam int unsigned CurveLinDen    = 32946;
  localparam int unsigned CurveGammaStep = 20;
  localparam int unsigned CurveGammaOff  = 561;
  localparam int unsigned CurveGammaDen  = 10761;
  localparam int unsigned CurveExpNum    = 12;
  localparam int unsigned CurveExpDen    = 5;
  localparam int unsigned BigW           = 320;

  typedef enum logic [1:0] {
    RegThreshold   = 2'd0,
    RegRedWeight   = 2'd1,
    RegGreenWeight = 2'd2,
    RegBlueWeight  = 2'd3
  } slt_reg_e;

  typedef struct packed {
    logic [WeightW-1:0] red;
    logic [WeightW-1:0] green;
    logic [WeightW-1:0] blue;
  } slt_weights_t;

  // wide integer power, elaboration only
  function automatic logic [BigW-1:0] big_pow(input logic [BigW-1:0] base,
                                              input int unsigned e);
    logic [BigW-1:0] acc;
    acc = BigW'(1);
    for (int unsigned j = 0; j < e; j++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // floor(f(n/510) * scale), exact
  function automatic logic [31:0] curve_floor(input int unsigned n,
                                              input int unsigned scale);
    logic [63:0]     lin;
    logic [BigW-1:0] rhs;
    logic [BigW-1:0] lhs;
    logic [BigW-1:0] den;
    int unsigned     p;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    lin = (64'(scale) * 64'd5 * 64'(n)) / 64'(CurveLinDen);
    if (n <= CurveLinKnee) begin
      return lin[31:0];
    end
    // largest y with y^5 * den^12 <= scale^5 * p^12
    p   = CurveGammaStep * n + CurveGammaOff;
    rhs = big_pow(BigW'(scale), CurveExpDen) * big_pow(BigW'(p), CurveExpNum);
    den = big_pow(BigW'(CurveGammaDen), CurveExpNum);
    lo  = 0;
    hi  = scale + 1;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      lhs = big_pow(BigW'(mid), CurveExpDen) * den;
      if (lhs <= rhs) lo = mid;
      else hi = mid;
    end
    return 32'(lo);
  endfunction

  // f(n/510) rounded half up to Q1.fb
  function automatic logic [31:0] curve_round(input int unsigned n,
                                              input int unsigned fb);
    logic [31:0] twice;
    twice = 32'd1 << (fb + 1);
    return (curve_floor(n, int'(twice)) + 32'd1) >> 1;
  endfunction

endpackage

[hdl/slt_pixel_if.sv]
// ----------------------------------------------------------------------------
// slt_pixel_if
// Valid/ready channel carrying one sRGB pixel per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slt_pixel_if;
  import slt_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] red;
  logic [PixW-1:0] green;
  logic [PixW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[hdl/slt_result_if.sv]
// ----------------------------------------------------------------------------
// slt_result_if
// Valid/ready channel carrying the binary pixel and brightness per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface slt_result_if;
  import slt_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] binary_pixel;
  logic [PixW-1:0] brightness;

  modport source (output valid, output binary_pixel, output brightness, input ready);
  modport sink   (input valid, input binary_pixel, input brightness, output ready);
endinterface

[hdl/slt_lin_mac.sv]
// ----------------------------------------------------------------------------
// slt_lin_mac
// Linearizes the three channels, weights them and sums with saturation
// to 1.0. Three register stages: lookup, multiply, add and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slt_lin_mac import slt_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FracBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  slt_pixel_if.sink                            pixel_i,
  input  slt_weights_t                         weights_i,
  output logic                                 sum_valid_o,
  input  logic                                 sum_ready_i,
  output logic [FRACTION_BITS+WeightBits:0]    sum_o
);

  localparam int unsigned LinW  = FRACTION_BITS + 1;
  localparam int unsigned ProdW = LinW + WeightW;
  localparam int unsigned RawW  = ProdW + 2;
  localparam int unsigned SumW  = FRACTION_BITS + WeightBits + 1;
  localparam logic [SumW-1:0] One = {1'b1, {(SumW-1){1'b0}}};

  // inverse gamma table, built at elaboration
  logic [LinW-1:0] lin_tab [NumLevels];

  for (genvar i = 0; i < NumLevels; i++) begin : g_lin
    localparam logic [31:0] LinVal = curve_round(2 * i, FRACTION_BITS);
    assign lin_tab[i] = LinVal[LinW-1:0];
  end

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  logic [LinW-1:0]  lin_r_q, lin_g_q, lin_b_q;
  logic [ProdW-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [SumW-1:0]  sum_q;
  logic [SumW-1:0]  sum_d;
  logic [RawW-1:0]  raw_sum;

  // stage readiness, a bubble in any stage lets the upstream advance
  assign s3_ready      = !s3_valid_q || sum_ready_i;
  assign s2_ready      = !s2_valid_q || s3_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign pixel_i.ready = s1_ready;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= pixel_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // stage 1: table lookup
  always_ff @(posedge clk_i) begin
    if (s1_ready && pixel_i.valid) begin
      lin_r_q <= lin_tab[pixel_i.red];
      lin_g_q <= lin_tab[pixel_i.green];
      lin_b_q <= lin_tab[pixel_i.blue];
    end
  end

  // stage 2: weight multiply
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      prod_r_q <= ProdW'(weights_i.red)   * ProdW'(lin_r_q);
      prod_g_q <= ProdW'(weights_i.green) * ProdW'(lin_g_q);
      prod_b_q <= ProdW'(weights_i.blue)  * ProdW'(lin_b_q);
    end
  end

  // stage 3: sum and clamp to 1.0
  assign raw_sum = RawW'(prod_r_q) + RawW'(prod_g_q) + RawW'(prod_b_q);
  assign sum_d   = (raw_sum > RawW'(One)) ? One : raw_sum[SumW-1:0];

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      sum_q <= sum_d;
    end
  end

  assign sum_valid_o = s3_valid_q;
  assign sum_o       = sum_q;

`ifndef ASSERT_OFF
  a_sum_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (sum_q <= One))
    else $error("saturated sum exceeds one");

  a_sum_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !sum_ready_i) |=> (s3_valid_q && $stable(sum_q)))
    else $error("stalled sum lost or changed");
`endif

endmodule

[hdl/slt_gamma_enc.sv]
// ----------------------------------------------------------------------------
// slt_gamma_enc
// Re-encodes the linear sum with the sRGB gamma by comparing it with the
// decision boundaries, then encodes the level and applies the threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slt_gamma_enc import slt_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              sum_valid_i,
  output logic                              sum_ready_o,
  input  logic [FRACTION_BITS+WeightBits:0] sum_i,
  input  logic [PixW-1:0]                   threshold_i,
  slt_result_if.source                      result_o
);

  localparam int unsigned LinW = FRACTION_BITS + 1;

  // decision boundaries, built at elaboration
  logic [LinW-1:0] edge_tab [NumEdges];

  for (genvar k = 0; k < NumEdges; k++) begin : g_edge
    localparam logic [31:0] EdgeVal = curve_round(2 * k + 1, FRACTION_BITS);
    assign edge_tab[k] = EdgeVal[LinW-1:0];
  end

  logic s4_valid_q, s5_valid_q;
  logic s4_ready, s5_ready;

  logic [NumEdges-1:0]  therm_d, therm_q;
  logic [NumLevels-1:0] therm_pad;
  logic [PixW-1:0]      level;
  logic [PixW-1:0]      bright_q, binary_q;

  assign s5_ready    = !s5_valid_q || result_o.ready;
  assign s4_ready    = !s4_valid_q || s5_ready;
  assign sum_ready_o = s4_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s4_ready) s4_valid_q <= sum_valid_i;
      if (s5_ready) s5_valid_q <= s4_valid_q;
    end
  end

  // stage 4: compare with every boundary, gives a thermometer code
  always_comb begin
    for (int k = 0; k < NumEdges; k++) begin
      therm_d[k] = (sum_i >= {edge_tab[k], {WeightBits{1'b0}}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && sum_valid_i) begin
      therm_q <= therm_d;
    end
  end

  // stage 5: thermometer to level, one bit per step from the top
  assign therm_pad = {1'b0, therm_q};

  always_comb begin
    logic [PixW-1:0] probe;
    level = '0;
    for (int b = PixW - 1; b >= 0; b--) begin
      probe = level | PixW'((1 << b) - 1);
      if (therm_pad[probe]) level = level | PixW'(1 << b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_ready && s4_valid_q) begin
      bright_q <= level;
      binary_q <= (level < threshold_i) ? PixBlack : PixWhite;
    end
  end

  assign result_o.valid        = s5_valid_q;
  assign result_o.brightness   = bright_q;
  assign result_o.binary_pixel = binary_q;

`ifndef ASSERT_OFF
  a_therm_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> (((therm_q >> 1) & ~therm_q) == '0))
    else $error("boundary compare is not a thermometer code");

  a_binary_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_valid_q |-> ((binary_q == PixWhite) == (bright_q >= threshold_i)))
    else $error("binary pixel disagrees with brightness and threshold");
`endif

endmodule

[hdl/srgb_luminance_threshold_core.sv]
// ----------------------------------------------------------------------------
// srgb_luminance_threshold_core
// Throughput: one pixel per cycle while result_o.ready holds, set by the
// five-stage pipeline (lookup, multiply, sum, boundary compare, encode and threshold).
// Reset clears all stage valid bits and loads the register defaults
// (threshold 128, weights 13933 / 46871 / 4732); the tables need no fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srgb_luminance_threshold_core import slt_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  slt_pixel_if.sink           pixel_i,
  slt_result_if.source        result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [RegDataW-1:0] pwdata,
  output logic [RegDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned SumW = FRACTION_BITS + WeightBits + 1;

  logic [PixW-1:0] threshold_q;
  slt_weights_t    weights_q;
  slt_reg_e        reg_sel;
  logic            reg_wr;

  logic            sum_valid;
  logic            sum_ready;
  logic [SumW-1:0] sum;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = slt_reg_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q     <= ThresholdReset;
      weights_q.red   <= RedWeightReset;
      weights_q.green <= GreenWeightReset;
      weights_q.blue  <= BlueWeightReset;
    end else if (reg_wr) begin
      unique case (reg_sel)
        RegThreshold:   threshold_q     <= pwdata[PixW-1:0];
        RegRedWeight:   weights_q.red   <= pwdata[WeightW-1:0];
        RegGreenWeight: weights_q.green <= pwdata[WeightW-1:0];
        RegBlueWeight:  weights_q.blue  <= pwdata[WeightW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      RegThreshold:   prdata = RegDataW'(threshold_q);
      RegRedWeight:   prdata = RegDataW'(weights_q.red);
      RegGreenWeight: prdata = RegDataW'(weights_q.green);
      RegBlueWeight:  prdata = RegDataW'(weights_q.blue);
      default:        prdata = '0;
    endcase
  end

  // linearize, weight and sum
  slt_lin_mac #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lin_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pixel_i),
    .weights_i   (weights_q),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_o       (sum)
  );

  // gamma encode and threshold
  slt_gamma_enc #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_gamma_enc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .sum_i       (sum),
    .threshold_i (threshold_q),
    .result_o    (result_o)
  );

endmodule
